// ===== src/robin_hood_hash_table_top_assert.svh =====
// Assertion macros shared by the checker of the hash table.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
// Antecedent holds in a cycle, consequent in the same cycle.
`define RH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent holds in a cycle, consequent in the following cycle.
`define RH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/rh_pkg.sv =====
// ----------------------------------------------------------------------------
// rh_pkg
// Types, codes and constants shared by the hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none
package rh_pkg;

  localparam int HASH_W          = 48;
  localparam int VALUE_W         = 32;
  localparam int KIND_W          = 3;
  localparam int START_W         = 9;
  localparam int STATUS_W        = 3;
  localparam int SLOT_W          = 8;
  localparam int COUNT_W         = 9;
  localparam int LIMIT_W         = 9;
  localparam int TABLE_DEPTH_DEF = 256;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_SCAN   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_REPLACED  = 3'd1,
    RES_FOUND     = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_REMOVED   = 3'd4,
    RES_FULL      = 3'd5,
    RES_SCAN_END  = 3'd6
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [HASH_W-1:0]  key_hash;
    logic [VALUE_W-1:0] value_in;
    logic [START_W-1:0] start_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_LOAD_SCAN,
    DP_LOAD_CLR,
    DP_FIND_BEGIN,
    DP_FIND_NEXT,
    DP_REPLACE,
    DP_REM_BEGIN,
    DP_REM_SHIFT,
    DP_REM_END,
    DP_INS_BEGIN,
    DP_INS_SWAP,
    DP_INS_SKIP,
    DP_INS_END,
    DP_SCAN_NEXT,
    DP_CLR_STEP
  } dp_op_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_HIT,
    SRC_SAVED
  } src_e;

  typedef struct packed {
    dp_op_e  op;
    logic    emit;
    status_e status;
    src_e    src;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] new_kind;
    logic              new_scan_oob;
    logic [KIND_W-1:0] op_kind;
    logic              home_done;
    logic              rd_empty;
    logic              rd_match;
    logic              rd_lt;
    logic              rd_le1;
    logic              probe_last;
    logic              shift_last;
    logic              idx_last;
    logic              full;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/rh_home.sv =====
// ----------------------------------------------------------------------------
// rh_home
// Home slot unit: the key hash modulo the table depth.
// ----------------------------------------------------------------------------
`default_nettype none
module rh_home #(
  parameter int DEPTH = rh_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [rh_pkg::HASH_W-1:0] hash,
  output logic                           done,
  output logic [$clog2(DEPTH)-1:0]       home
);
  import rh_pkg::*;

  localparam int IW = $clog2(DEPTH);

  generate
    if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
      // A power-of-two depth takes the low bits of the hash.
      logic          done_r;
      logic [IW-1:0] home_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= go;
        end
        if (go) begin
          home_r <= hash[IW-1:0];
        end
      end

      assign done = done_r;
      assign home = home_r;
    end else begin : g_fold
      // Each hash byte is weighted by 2^(8k) mod DEPTH, the weighted sum is
      // reduced by a reciprocal multiply and one correction, each step registered.
      localparam int NB   = HASH_W / 8;
      localparam int SUMW = IW + 11;
      localparam logic [SUMW-1:0] RECIP = SUMW'((64'd1 << SUMW) / DEPTH);
      localparam logic [SUMW-1:0] DEP_S = SUMW'(DEPTH);
      localparam logic [IW:0]     DEP_R = (IW+1)'(DEPTH);

      logic [SUMW-1:0]   term [NB];
      logic [SUMW-1:0]   sum;
      logic [2*SUMW-1:0] prod;
      logic [SUMW-1:0]   diff;
      logic [IW:0]       rc;
      logic [3:0]        vld_r;
      logic [SUMW-1:0]   sum_r;
      logic [SUMW-1:0]   q_r;
      logic [IW:0]       r_r;
      logic [IW-1:0]     home_r;

      for (genvar k = 0; k < NB; k++) begin : g_term
        localparam longint unsigned WGT_L = (64'd1 << (8 * k)) % DEPTH;
        localparam logic [SUMW-1:0] WGT   = SUMW'(WGT_L);
        assign term[k] = SUMW'(hash[8*k +: 8]) * WGT;
      end

      always_comb begin
        sum = '0;
        for (int k = 0; k < NB; k++) begin
          sum = sum + term[k];
        end
        // The estimate is at most one below the true quotient.
        prod = {{SUMW{1'b0}}, sum_r} * {{SUMW{1'b0}}, RECIP};
        diff = sum_r - q_r * DEP_S;
        rc   = (r_r >= DEP_R) ? r_r - DEP_R : r_r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r <= '0;
        end else begin
          vld_r <= {vld_r[2:0], go};
        end
        if (go) begin
          sum_r <= sum;
        end
        if (vld_r[0]) begin
          q_r <= prod[2*SUMW-1:SUMW];
        end
        if (vld_r[1]) begin
          r_r <= diff[IW:0];
        end
        if (vld_r[2]) begin
          home_r <= rc[IW-1:0];
        end
      end

      assign done = vld_r[3];
      assign home = home_r;
    end
  endgenerate
endmodule
`default_nettype wire

// ===== src/rh_datapath.sv =====
// ----------------------------------------------------------------------------
// rh_datapath
// Slot memory, probe registers, entry count, fill limit and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rh_datapath #(
  parameter int DEPTH = rh_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rh_pkg::in_item_t           in_data,
  input  wire logic                       cfg_we,
  input  wire logic [rh_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire rh_pkg::cmd_t               cmd,
  output rh_pkg::stat_t                   stat,
  output logic                            out_valid,
  output rh_pkg::out_item_t               out_data
);
  import rh_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + LIMIT_W;
  localparam int SW = START_W + CW;
  localparam logic [LIMIT_W-1:0] FILL_RST = LIMIT_W'((DEPTH * 6 / 10) % 512);

  typedef struct packed {
    logic [HASH_W-1:0]  h;
    logic [VALUE_W-1:0] v;
    logic [CW-1:0]      d;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_r;
  logic rd_en;
  logic [IW-1:0] rd_addr;
  logic we;
  ent_t wd;

  in_item_t op_r, op_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  ent_t car_r, car_nxt;
  logic placed_r, placed_nxt;
  logic [VALUE_W-1:0] sv_r, sv_nxt;
  logic [IW-1:0] ss_r, ss_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [LIMIT_W-1:0] fill_r;
  logic out_valid_r;
  out_item_t out_r, out_nxt;

  logic home_done;
  logic [IW-1:0] home;
  logic [IW-1:0] nidx, nnidx;
  logic [SW-1:0] start_ext;
  logic [IW-1:0] slot_sel;
  logic [VALUE_W-1:0] val_sel;
  logic [IW+SLOT_W-1:0] slot_ext;
  logic [CW+COUNT_W-1:0] cnt_ext;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  rh_home #(.DEPTH(DEPTH)) u_home (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.op == DP_LOAD),
    .hash (in_data.key_hash),
    .done (home_done),
    .home (home)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r] <= wd;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign nidx      = nxt(idx_r);
  assign nnidx     = nxt(nidx);
  assign start_ext = {{CW{1'b0}}, in_data.start_index};

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = nidx;
    we         = 1'b0;
    wd         = car_r;
    op_nxt     = op_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    car_nxt    = car_r;
    placed_nxt = placed_r;
    sv_nxt     = sv_r;
    ss_nxt     = ss_r;
    count_nxt  = count_r;
    case (cmd.op)
      DP_LOAD: begin
        op_nxt = in_data;
      end
      DP_LOAD_SCAN: begin
        op_nxt  = in_data;
        idx_nxt = start_ext[IW-1:0];
        rd_en   = 1'b1;
        rd_addr = start_ext[IW-1:0];
      end
      DP_LOAD_CLR: begin
        idx_nxt   = '0;
        count_nxt = '0;
      end
      DP_FIND_BEGIN: begin
        rd_en   = 1'b1;
        rd_addr = home;
        idx_nxt = home;
        n_nxt   = '0;
      end
      DP_FIND_NEXT: begin
        rd_en   = 1'b1;
        idx_nxt = nidx;
        n_nxt   = n_r + 1'b1;
      end
      DP_REPLACE: begin
        we = 1'b1;
        wd = '{h: rd_r.h, v: op_r.value_in, d: rd_r.d};
      end
      DP_REM_BEGIN: begin
        sv_nxt     = rd_r.v;
        ss_nxt     = idx_r;
        placed_nxt = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        n_nxt = '0;
        rd_en = 1'b1;
      end
      DP_REM_SHIFT: begin
        we      = 1'b1;
        wd      = '{h: rd_r.h, v: rd_r.v, d: rd_r.d - CW'(1)};
        idx_nxt = nidx;
        n_nxt   = n_r + 1'b1;
        rd_en   = 1'b1;
        rd_addr = nnidx;
      end
      DP_REM_END: begin
        we = 1'b1;
        wd = '{h: rd_r.h, v: rd_r.v, d: '0};
      end
      DP_INS_BEGIN: begin
        rd_en      = 1'b1;
        rd_addr    = home;
        idx_nxt    = home;
        car_nxt    = '{h: op_r.key_hash, v: op_r.value_in, d: CW'(1)};
        placed_nxt = 1'b0;
        sv_nxt     = '0;
      end
      DP_INS_SWAP: begin
        we      = 1'b1;
        car_nxt = '{h: rd_r.h, v: rd_r.v, d: rd_r.d + CW'(1)};
        if (!placed_r) begin
          ss_nxt     = idx_r;
          placed_nxt = 1'b1;
        end
        idx_nxt = nidx;
        rd_en   = 1'b1;
      end
      DP_INS_SKIP: begin
        car_nxt.d = car_r.d + CW'(1);
        idx_nxt   = nidx;
        rd_en     = 1'b1;
      end
      DP_INS_END: begin
        we        = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      DP_SCAN_NEXT: begin
        idx_nxt = nidx;
        rd_en   = 1'b1;
      end
      DP_CLR_STEP: begin
        we      = 1'b1;
        wd      = '0;
        idx_nxt = nidx;
      end
      default: begin
      end
    endcase
  end

  // Result payload; the saved slot of an insert is the first slot it took.
  always_comb begin
    case (cmd.src)
      SRC_HIT: begin
        val_sel  = rd_r.v;
        slot_sel = idx_r;
      end
      SRC_SAVED: begin
        val_sel  = sv_r;
        slot_sel = placed_r ? ss_r : idx_r;
      end
      default: begin
        val_sel  = '0;
        slot_sel = '0;
      end
    endcase
    slot_ext = {{SLOT_W{1'b0}}, slot_sel};
    cnt_ext  = {{COUNT_W{1'b0}}, count_nxt};
    out_nxt  = out_r;
    if (cmd.emit) begin
      out_nxt.status      = cmd.status;
      out_nxt.value_out   = val_sel;
      out_nxt.slot_index  = slot_ext[SLOT_W-1:0];
      out_nxt.entry_count = cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      fill_r      <= FILL_RST;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
      if (cfg_we) begin
        fill_r <= cfg_wdata;
      end
    end
    op_r     <= op_nxt;
    n_r      <= n_nxt;
    car_r    <= car_nxt;
    placed_r <= placed_nxt;
    sv_r     <= sv_nxt;
    ss_r     <= ss_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    stat.new_kind     = in_data.kind;
    stat.new_scan_oob = start_ext >= SW'(DEPTH);
    stat.op_kind      = op_r.kind;
    stat.home_done    = home_done;
    stat.rd_empty     = rd_r.d == '0;
    stat.rd_match     = rd_r.h == op_r.key_hash;
    stat.rd_lt        = rd_r.d < car_r.d;
    stat.rd_le1       = rd_r.d <= CW'(1);
    stat.probe_last   = n_r == CW'(DEPTH - 1);
    stat.shift_last   = n_r == CW'(DEPTH);
    stat.idx_last     = idx_r == IW'(DEPTH - 1);
    stat.full         = (XW'(count_r) >= XW'(fill_r)) || (count_r >= CW'(DEPTH));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ===== src/rh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rh_ctrl
// Operation sequencer: probe, insert, shift-back, scan and clear walks.
// ----------------------------------------------------------------------------
`default_nettype none
module rh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire rh_pkg::stat_t stat,
  output logic               busy,
  output rh_pkg::cmd_t       cmd
);
  import rh_pkg::*;

  typedef enum logic [6:0] {
    ST_SWEEP = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HOME  = 7'b0000100,
    ST_FIND  = 7'b0001000,
    ST_INS   = 7'b0010000,
    ST_REM   = 7'b0100000,
    ST_SCAN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_op_r, clr_op_nxt;
  logic   hit;

  assign hit = !stat.rd_empty && stat.rd_match;

  always_comb begin
    state_nxt  = state_r;
    clr_op_nxt = clr_op_r;
    cmd        = '{op: DP_NOP, emit: 1'b0, status: RES_NOT_FOUND, src: SRC_ZERO};
    case (state_r)
      ST_SWEEP: begin
        cmd.op = DP_CLR_STEP;
        if (stat.idx_last) begin
          state_nxt  = ST_IDLE;
          clr_op_nxt = 1'b0;
          if (clr_op_r) begin
            cmd.emit   = 1'b1;
            cmd.status = RES_REMOVED;
          end
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (stat.new_kind)
            KIND_INSERT, KIND_LOOKUP, KIND_REMOVE: begin
              cmd.op    = DP_LOAD;
              state_nxt = ST_HOME;
            end
            KIND_SCAN: begin
              if (stat.new_scan_oob) begin
                cmd.emit   = 1'b1;
                cmd.status = RES_SCAN_END;
              end else begin
                cmd.op    = DP_LOAD_SCAN;
                state_nxt = ST_SCAN;
              end
            end
            KIND_CLEAR: begin
              cmd.op     = DP_LOAD_CLR;
              clr_op_nxt = 1'b1;
              state_nxt  = ST_SWEEP;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      ST_HOME: begin
        if (stat.home_done) begin
          cmd.op    = DP_FIND_BEGIN;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        if (hit) begin
          case (stat.op_kind)
            KIND_INSERT: begin
              cmd       = '{op: DP_REPLACE, emit: 1'b1, status: RES_REPLACED, src: SRC_HIT};
              state_nxt = ST_IDLE;
            end
            KIND_REMOVE: begin
              cmd.op    = DP_REM_BEGIN;
              state_nxt = ST_REM;
            end
            default: begin
              cmd       = '{op: DP_NOP, emit: 1'b1, status: RES_FOUND, src: SRC_HIT};
              state_nxt = ST_IDLE;
            end
          endcase
        end else if (stat.rd_empty || stat.probe_last) begin
          if (stat.op_kind == KIND_INSERT && !stat.full) begin
            cmd.op    = DP_INS_BEGIN;
            state_nxt = ST_INS;
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = (stat.op_kind == KIND_INSERT) ? RES_FULL : RES_NOT_FOUND;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.op = DP_FIND_NEXT;
        end
      end
      ST_INS: begin
        if (stat.rd_empty) begin
          cmd       = '{op: DP_INS_END, emit: 1'b1, status: RES_INSERTED, src: SRC_SAVED};
          state_nxt = ST_IDLE;
        end else if (stat.rd_lt) begin
          cmd.op = DP_INS_SWAP;
        end else begin
          cmd.op = DP_INS_SKIP;
        end
      end
      ST_REM: begin
        if (stat.shift_last || stat.rd_le1) begin
          cmd       = '{op: DP_REM_END, emit: 1'b1, status: RES_REMOVED, src: SRC_SAVED};
          state_nxt = ST_IDLE;
        end else begin
          cmd.op = DP_REM_SHIFT;
        end
      end
      ST_SCAN: begin
        if (!stat.rd_empty) begin
          cmd       = '{op: DP_NOP, emit: 1'b1, status: RES_FOUND, src: SRC_HIT};
          state_nxt = ST_IDLE;
        end else if (stat.idx_last) begin
          cmd.emit   = 1'b1;
          cmd.status = RES_SCAN_END;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.op = DP_SCAN_NEXT;
        end
      end
      default: begin
        state_nxt  = ST_SWEEP;
        clr_op_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_SWEEP;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;
endmodule
`default_nettype wire

// ===== src/robin_hood_hash_table_top.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_top
// Fixed-size Robin Hood hash table keyed by a 48-bit hash.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken at a rising edge where start is high and busy
// is low; in_data carries the kind, hash, value and scan start. Every command
// gives exactly one result beat: out_valid is high for one cycle with out_data.
// The receiver cannot stall, so the result must be taken in that cycle.
// Timing. The slot memory has one read and one write port with a registered
// read, so the probe walks one slot per cycle. A lookup first takes the home
// slot from the hash: its low bits at a power-of-two depth, else the result of
// a pipelined remainder unit; then it probes until a hit, an empty slot or a
// full lap. A new insert adds a second walk from the home slot to the first
// empty slot; a remove adds a walk that shifts the following entries back. A
// scan walks one slot per cycle to the next occupied slot. Unknown kinds and
// out-of-range scans answer in the cycle after the beat. A clear sweeps all
// TABLE_DEPTH slots. Reset. After rst_n the block runs the same sweep with
// busy high; configuration writes (cfg_we, cfg_wdata for the fill limit) are
// taken at any time, and the fill limit resets to 60 percent of the depth.
// ----------------------------------------------------------------------------
`default_nettype none
module robin_hood_hash_table_top #(
  parameter int TABLE_DEPTH = rh_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire rh_pkg::in_item_t           in_data,
  output logic                            out_valid,
  output rh_pkg::out_item_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [rh_pkg::LIMIT_W-1:0] cfg_wdata
);
  import rh_pkg::*;

  // Commands flow from the sequencer to the datapath, status flows back.
  cmd_t  cmd;
  stat_t stat;

  rh_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  rh_datapath #(.DEPTH(TABLE_DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );
endmodule
`default_nettype wire

// ===== src/rh_checker.sv =====
// ----------------------------------------------------------------------------
// rh_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "robin_hood_hash_table_top_assert.svh"
module rh_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire rh_pkg::out_item_t out_data
);
  import rh_pkg::*;

  `RH_ASSERT_NEXT(a_accept_runs, start && !busy, busy || out_valid, "beat dropped")
  `RH_ASSERT_NOW(a_result_cause, out_valid, $past(busy || start), "result without command")
  `RH_ASSERT_NOW(a_insert_count, out_valid && out_data.status == RES_INSERTED, out_data.entry_count != '0, "insert left table empty")
  `RH_ASSERT_NOW(a_full_zero, out_valid && out_data.status == RES_FULL, out_data.value_out == '0 && out_data.slot_index == '0, "full result not zero")
endmodule

bind robin_hood_hash_table_top rh_checker u_rh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
`default_nettype wire

// ===== tb/sv/robin_hood_hash_table_top_test.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_top_test
// Self-checking testbench for the Robin Hood hash table.
// ----------------------------------------------------------------------------
// A queue of pending steps (command beats, fill limit writes and hold points)
// is filled by an initial block. A clocked driver feeds command beats to the
// block with random gaps. At each accepted beat, a predictor computes the
// expected result from its own copy of the table. A clocked monitor compares
// every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module robin_hood_hash_table_top_test;
  import rh_pkg::*;

  localparam int DEPTH = 256;

  // Kinds above the last defined one must be ignored by the block.
  localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

  typedef enum logic [1:0] {
    STEP_CMD,
    STEP_CFG,
    STEP_HOLD
  } step_e;

  typedef struct {
    step_e              tag;
    in_item_t           cmd;
    logic [LIMIT_W-1:0] limit;
  } step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [LIMIT_W-1:0]   cfg_wdata;

  robin_hood_hash_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the table for the predictor; the driver resets it and sets its limit.
  logic [HASH_W-1:0]  tbl_hash [DEPTH];
  logic [VALUE_W-1:0] tbl_value [DEPTH];
  int unsigned        tbl_dist [DEPTH];
  int unsigned        tbl_count;
  int unsigned        tbl_limit;

  step_t              pending_steps[$];
  out_item_t          expected_results[$];
  logic [HASH_W-1:0]  hash_pool[$];

  int unsigned        cmd_total;
  int unsigned        cmd_driven;
  int unsigned        mismatches;
  int unsigned        status_seen [8];
  int unsigned        gap;
  int unsigned        settle;
  bit                 stim_done;

  // Clock and a single reset pulse at the start of the run.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Probe from the home slot until an empty slot or a full lap.
  function automatic bit locate(input logic [HASH_W-1:0] h, output int unsigned pos);
    int unsigned i;
    i = h % DEPTH;
    pos = 0;
    for (int n = 0; n < DEPTH; n++) begin
      if (tbl_dist[i] == 0) return 1'b0;
      if (tbl_hash[i] == h) begin
        pos = i;
        return 1'b1;
      end
      i = (i + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow table and return the result it must give.
  function automatic out_item_t predict_result(input in_item_t c);
    out_item_t r;
    int unsigned pos, i, j, cd, td;
    logic [HASH_W-1:0] ch, th;
    logic [VALUE_W-1:0] cv, tv;
    bit placed;
    r = '0;
    r.status = RES_NOT_FOUND;
    case (c.kind)
      KIND_INSERT: begin
        if (locate(c.key_hash, pos)) begin
          // A matching hash is replaced even at the fill limit.
          r.value_out = tbl_value[pos];
          tbl_value[pos] = c.value_in;
          r.status = RES_REPLACED;
          r.slot_index = pos[SLOT_W-1:0];
        end else if (tbl_count >= tbl_limit || tbl_count >= DEPTH) begin
          r.status = RES_FULL;
        end else begin
          ch = c.key_hash;
          cv = c.value_in;
          cd = 1;
          i = c.key_hash % DEPTH;
          placed = 1'b0;
          for (int n = 0; n < DEPTH; n++) begin
            if (tbl_dist[i] == 0) begin
              tbl_hash[i] = ch;
              tbl_value[i] = cv;
              tbl_dist[i] = cd;
              if (!placed) r.slot_index = i[SLOT_W-1:0];
              placed = 1'b1;
              break;
            end
            if (tbl_dist[i] < cd) begin
              // The carried entry is poorer, so it takes this slot.
              th = tbl_hash[i];
              tv = tbl_value[i];
              td = tbl_dist[i];
              tbl_hash[i] = ch;
              tbl_value[i] = cv;
              tbl_dist[i] = cd;
              ch = th;
              cv = tv;
              cd = td;
              if (!placed) r.slot_index = i[SLOT_W-1:0];
              placed = 1'b1;
            end
            i = (i + 1) % DEPTH;
            cd++;
          end
          tbl_count++;
          r.status = RES_INSERTED;
        end
      end
      KIND_LOOKUP: begin
        if (locate(c.key_hash, pos)) begin
          r.status = RES_FOUND;
          r.value_out = tbl_value[pos];
          r.slot_index = pos[SLOT_W-1:0];
        end
      end
      KIND_REMOVE: begin
        if (locate(c.key_hash, pos)) begin
          r.status = RES_REMOVED;
          r.value_out = tbl_value[pos];
          r.slot_index = pos[SLOT_W-1:0];
          i = pos;
          tbl_dist[i] = 0;
          // Backward shift until an empty slot or an entry at its home.
          for (int n = 0; n < DEPTH; n++) begin
            j = (i + 1) % DEPTH;
            if (tbl_dist[j] <= 1) break;
            tbl_hash[i] = tbl_hash[j];
            tbl_value[i] = tbl_value[j];
            tbl_dist[i] = tbl_dist[j] - 1;
            tbl_dist[j] = 0;
            i = j;
          end
          if (tbl_count > 0) tbl_count--;
        end
      end
      KIND_SCAN: begin
        r.status = RES_SCAN_END;
        for (int unsigned k = c.start_index; k < DEPTH; k++) begin
          if (tbl_dist[k] != 0) begin
            r.status = RES_FOUND;
            r.value_out = tbl_value[k];
            r.slot_index = k[SLOT_W-1:0];
            break;
          end
        end
      end
      KIND_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) tbl_dist[k] = 0;
        tbl_count = 0;
        r.status = RES_REMOVED;
      end
      default: ;
    endcase
    r.entry_count = tbl_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic push_cmd(input logic [KIND_W-1:0] k, input logic [HASH_W-1:0] h,
                          input logic [VALUE_W-1:0] v, input logic [START_W-1:0] s);
    step_t st;
    st.tag = STEP_CMD;
    st.cmd.kind = k;
    st.cmd.key_hash = h;
    st.cmd.value_in = v;
    st.cmd.start_index = s;
    st.limit = '0;
    pending_steps.push_back(st);
    cmd_total++;
  endtask

  task automatic push_cfg(input logic [LIMIT_W-1:0] lim);
    step_t st;
    st.tag = STEP_CFG;
    st.cmd = '0;
    st.limit = lim;
    pending_steps.push_back(st);
  endtask

  task automatic push_hold();
    step_t st;
    st.tag = STEP_HOLD;
    st.cmd = '0;
    st.limit = '0;
    pending_steps.push_back(st);
  endtask

  function automatic logic [HASH_W-1:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  // One phase: a new fill limit, a clear, an optional bulk fill, then a mix of
  // commands whose hashes mostly come from a pool of hashes clustered on a few home slots and of the bulk fill.
  task automatic add_phase(input logic [LIMIT_W-1:0] lim, input int fill, input int n);
    logic [HASH_W-1:0] h;
    logic [7:0] base;
    int unsigned pick;
    logic [KIND_W-1:0] k;
    hash_pool.delete();
    base = $urandom_range(0, 255);
    for (int p = 0; p < 48; p++) begin
      h = rand_hash();
      h[7:0] = base + 8'($urandom_range(0, 20));
      hash_pool.push_back(h);
    end
    push_cfg(lim);
    push_cmd(KIND_CLEAR, rand_hash(), $urandom, 9'($urandom));
    for (int f = 0; f < fill; f++) begin
      h = rand_hash();
      hash_pool.push_back(h);
      push_cmd(KIND_INSERT, h, $urandom, 9'($urandom));
    end
    for (int q = 0; q < n; q++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) k = KIND_INSERT;
      else if (pick < 60) k = KIND_LOOKUP;
      else if (pick < 82) k = KIND_REMOVE;
      else if (pick < 95) k = KIND_SCAN;
      else if (pick < 97) k = KIND_CLEAR;
      else k = 3'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
      if ($urandom_range(0, 3) != 0) h = hash_pool[$urandom_range(0, hash_pool.size() - 1)];
      else h = rand_hash();
      push_cmd(k, h, $urandom, ($urandom_range(0, 9) == 0) ? 9'($urandom_range(256, 511))
                                                           : 9'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus: directed cases first, then random phases across fill limits.
  initial begin
    cmd_total = 0;
    stim_done = 1'b0;
    // Empty table answers.
    push_cmd(KIND_LOOKUP, 48'h0, 32'h0, 9'd0);
    push_cmd(KIND_REMOVE, 48'hFFFF_FFFF_FFFF, 32'h0, 9'd0);
    push_cmd(KIND_SCAN, 48'h0, 32'h0, 9'd0);
    // Inserts at the hash and value extremes, then a replace.
    push_cmd(KIND_INSERT, 48'h0, 32'h0, 9'd0);
    push_cmd(KIND_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF);
    push_cmd(KIND_INSERT, 48'hFFFF_FFFF_FFFF, 32'h1234_5678, 9'd0);
    // Entries sharing home slot 0, and one wrapping from the last slot.
    push_cmd(KIND_INSERT, 48'h100, 32'hA5A5_A5A5, 9'd0);
    push_cmd(KIND_INSERT, 48'h200, 32'h5A5A_5A5A, 9'd0);
    push_cmd(KIND_INSERT, 48'h3FF, 32'h0000_0001, 9'd0);
    push_cmd(KIND_LOOKUP, 48'h200, 32'h0, 9'd0);
    push_cmd(KIND_SCAN, 48'h0, 32'h0, 9'd1);
    push_cmd(KIND_SCAN, 48'h0, 32'h0, 9'd255);
    // Scans that start past the end of the table.
    push_cmd(KIND_SCAN, 48'h0, 32'h0, 9'd256);
    push_cmd(KIND_SCAN, 48'h0, 32'h0, 9'h1FF);
    // Remove with backward shift of the cluster, then lookups behind it.
    push_cmd(KIND_REMOVE, 48'h0, 32'h0, 9'd0);
    push_cmd(KIND_LOOKUP, 48'h200, 32'h0, 9'd0);
    push_cmd(KIND_LOOKUP, 48'h3FF, 32'h0, 9'd0);
    // Undefined kinds change nothing.
    push_cmd(3'd5, 48'h100, 32'hFFFF_FFFF, 9'd0);
    push_cmd(3'd7, 48'h100, 32'hFFFF_FFFF, 9'h1FF);
    push_cmd(KIND_CLEAR, 48'h0, 32'h0, 9'd0);
    push_cmd(KIND_LOOKUP, 48'h100, 32'h0, 9'd0);
    // Limit of one: a new insert is refused, a replace still goes through.
    push_cfg(9'd1);
    push_cmd(KIND_INSERT, 48'h77, 32'h1, 9'd0);
    push_cmd(KIND_INSERT, 48'h78, 32'h2, 9'd0);
    push_cmd(KIND_INSERT, 48'h77, 32'h3, 9'd0);
    // Limit of zero refuses every new insert.
    push_cfg(9'd0);
    push_cmd(KIND_INSERT, 48'h79, 32'h4, 9'd0);
    push_hold();
    // Random phases; the full-depth phase fills every slot.
    add_phase(9'd153, 0, 300);
    add_phase(9'd256, 262, 190);
    push_hold();
    add_phase(9'd7, 0, 150);
    add_phase(9'h1FF, 40, 210);
    add_phase(9'd40, 0, 200);
    add_phase(9'd1, 0, 40);
    stim_done = 1'b1;
  end

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    bit    fire;
    bit    nxt_start;
    bit    nxt_we;
    bit    idle;
    step_t st;
    if (!rst_n) begin
      start      <= 1'b0;
      in_data    <= '0;
      cfg_we     <= 1'b0;
      cfg_wdata  <= '0;
      gap        = 0;
      settle     = 0;
      cmd_driven = 0;
      tbl_count  = 0;
      tbl_limit  = DEPTH * 6 / 10;
      for (int k = 0; k < DEPTH; k++) tbl_dist[k] = 0;
    end else begin
      fire = start && !busy;
      nxt_start = start && !fire;
      nxt_we = 1'b0;
      if (fire) begin
        expected_results.push_back(predict_result(in_data));
        // The last stretch of the run goes without gaps.
        if (cmd_driven + 120 < cmd_total && $urandom_range(0, 9) < 3)
          gap = $urandom_range(1, 14);
      end
      idle = (expected_results.size() == 0) && !busy && !start;
      if (!idle) settle = 0;
      if (!nxt_start && pending_steps.size() > 0) begin
        st = pending_steps[0];
        if (gap > 0) begin
          gap--;
        end else if (st.tag == STEP_CMD) begin
          nxt_start = 1'b1;
          in_data <= st.cmd;
          cmd_driven++;
          void'(pending_steps.pop_front());
        end else if (idle) begin
          if (settle < 8) begin
            settle++;
          end else begin
            if (st.tag == STEP_CFG) begin
              nxt_we = 1'b1;
              cfg_wdata <= st.limit;
              tbl_limit = st.limit;
            end
            settle = 0;
            void'(pending_steps.pop_front());
          end
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = expected_results.pop_front();
        status_seen[out_data.status]++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d value %h/%h slot %0d/%0d count %0d/%0d",
                     out_data.status, want.status, out_data.value_out, want.value_out,
                     out_data.slot_index, want.slot_index,
                     out_data.entry_count, want.entry_count);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    for (int k = 0; k < 8; k++) status_seen[k] = 0;
    wait (stim_done);
    @(posedge clk);
    wait (pending_steps.size() == 0 && expected_results.size() == 0 && !start);
    repeat (300) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("covered %0d commands: %0d new inserts, %0d replaces, %0d found, %0d not found",
             cmd_total, status_seen[RES_INSERTED], status_seen[RES_REPLACED],
             status_seen[RES_FOUND], status_seen[RES_NOT_FOUND]);
    $display("  %0d removed or cleared, %0d refused as full, %0d scans past the last entry",
             status_seen[RES_REMOVED], status_seen[RES_FULL], status_seen[RES_SCAN_END]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/rh_pkg.sv
src/rh_home.sv
src/rh_datapath.sv
src/rh_ctrl.sv
src/robin_hood_hash_table_top.sv
src/rh_checker.sv
tb/sv/robin_hood_hash_table_top_test.sv
